>>> rtl/core/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

    // Kind of one input transaction
    typedef enum logic
    {
        KIND_DATA = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    // Classified input transaction carried from front to back
    typedef struct packed
    {
        item_kind_t kind;
        logic       last;
        logic [7:0] data;
    } item_t;

    // One result transaction
    typedef struct packed
    {
        logic [15:0] word;
        logic        chunk_end;
        logic        protocol_error;
    } result_t;

    // Decoupling queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Header field masks and group limits
    localparam logic [7:0] HDR_PAYLOAD_MASK = 8'h7f;
    localparam logic [7:0] HDR_FINAL_MASK   = 8'h80;
    localparam int         HDR_GROUP_BITS   = 7;
    localparam int         HDR_MAX_GROUPS   = 5;

endpackage

`default_nettype wire

>>> rtl/core/rsd_front.sv
`default_nettype none

module rsd_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_kind,
    input  wire logic [7:0]    in_data,
    input  wire logic          in_last,
    output logic               q_valid,
    input  wire logic          q_ready,
    output rsd_pkg::item_t     q_item
);

    logic           valid_reg;
    logic           valid_next;
    rsd_pkg::item_t item_reg;
    rsd_pkg::item_t item_next;

    // Accept whenever the stage is empty or draining this cycle
    assign in_ready = !valid_reg || q_ready;

    // Classify the incoming transaction
    always_comb
    begin
        item_next      = item_reg;
        valid_next     = valid_reg && !q_ready;
        if (in_valid && in_ready)
        begin
            valid_next     = 1'b1;
            item_next.kind = in_kind ? rsd_pkg::KIND_TICK : rsd_pkg::KIND_DATA;
            item_next.last = in_last;
            item_next.data = in_data;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

`default_nettype wire

>>> rtl/core/rsd_queue.sv
`default_nettype none

module rsd_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rsd_pkg::item_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rsd_pkg::item_t      out_item
);

    rsd_pkg::item_t                mem [rsd_pkg::Q_DEPTH];
    logic [rsd_pkg::Q_AW-1:0]      wr_ptr_reg;
    logic [rsd_pkg::Q_AW-1:0]      rd_ptr_reg;
    logic [rsd_pkg::Q_CW-1:0]      count_reg;
    logic                          push;
    logic                          pop;

    assign in_ready  = count_reg != rsd_pkg::Q_CW'(rsd_pkg::Q_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rsd_back.sv
`default_nettype none

module rsd_back
#(
    parameter int CHUNK_WORDS      = 512,
    parameter int MAX_HEADER_BYTES = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire rsd_pkg::item_t q_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rsd_pkg::result_t   out_res
);

    localparam int CNT_W = $clog2(CHUNK_WORDS + 1);

    typedef enum logic [2:0]
    {
        PH_HEADER,
        PH_REP_FIRST,
        PH_REP_SECOND,
        PH_EXPAND,
        PH_LIT_FIRST,
        PH_LIT_SECOND
    } phase_t;

    phase_t            phase_reg,   phase_next;
    logic [30:0]       run_reg,     run_next;
    logic [2:0]        hidx_reg,    hidx_next;
    logic [31:0]       acc_reg,     acc_next;
    logic [7:0]        held_reg,    held_next;
    logic [15:0]       rep_reg,     rep_next;
    logic [CNT_W-1:0]  chunk_reg,   chunk_next;
    logic              ending_reg,  ending_next;
    logic              ovalid_reg,  ovalid_next;
    rsd_pkg::result_t  ores_reg,    ores_next;

    logic              pop;
    logic              res_valid;
    rsd_pkg::result_t  res;
    logic              word_out;
    logic [CNT_W-1:0]  chunk_inc;
    logic              chunk_wrap;
    logic [5:0]        shamt;
    logic [38:0]       grp_shift;
    logic [31:0]       acc_new;
    logic [30:0]       run_dec;

    assign q_ready    = !ovalid_reg || out_ready;
    assign pop        = q_valid && q_ready;
    assign chunk_inc  = chunk_reg + 1'b1;
    assign chunk_wrap = chunk_inc == CNT_W'(CHUNK_WORDS);
    assign shamt      = 6'(hidx_reg) * 6'(rsd_pkg::HDR_GROUP_BITS);
    assign grp_shift  = 39'(q_item.data & rsd_pkg::HDR_PAYLOAD_MASK) << shamt;
    assign run_dec    = run_reg - 1'b1;

    // Decode one transaction per cycle while q_ready lets the queue pop
    always_comb
    begin
        phase_next  = phase_reg;
        run_next    = run_reg;
        hidx_next   = hidx_reg;
        acc_next    = acc_reg;
        held_next   = held_reg;
        rep_next    = rep_reg;
        chunk_next  = chunk_reg;
        ending_next = ending_reg;
        res_valid   = 1'b0;
        res         = '0;
        word_out    = 1'b0;
        acc_new     = acc_reg;

        if (pop)
        begin
            if (q_item.kind == rsd_pkg::KIND_TICK)
            begin
                // Emit one repeat word
                if (phase_reg == PH_EXPAND)
                begin
                    res_valid     = 1'b1;
                    res.word      = rep_reg;
                    res.chunk_end = chunk_wrap;
                    chunk_next    = chunk_wrap ? '0 : chunk_inc;
                    run_next      = run_dec;
                    if (run_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                        if (ending_reg)
                        begin
                            res.chunk_end = 1'b1;
                            hidx_next     = '0;
                            acc_next      = '0;
                            run_next      = '0;
                            chunk_next    = '0;
                            ending_next   = 1'b0;
                        end
                    end
                end
            end
            else if (phase_reg == PH_EXPAND)
            begin
                // Drop a data byte that arrives during expansion
                res_valid          = 1'b1;
                res.protocol_error = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (hidx_reg < 3'(MAX_HEADER_BYTES) &&
                            hidx_reg < 3'(rsd_pkg::HDR_MAX_GROUPS))
                        begin
                            acc_new   = acc_reg | grp_shift[31:0];
                            hidx_next = hidx_reg + 1'b1;
                        end
                        else
                        begin
                            res_valid          = 1'b1;
                            res.protocol_error = 1'b1;
                        end
                        acc_next = acc_new;
                        if ((q_item.data & rsd_pkg::HDR_FINAL_MASK) != '0)
                        begin
                            run_next = acc_new[31:1];
                            if (acc_new[0])
                            begin
                                phase_next = PH_REP_FIRST;
                            end
                            else
                            begin
                                phase_next = (acc_new[31:1] != '0) ? PH_LIT_FIRST
                                                                   : PH_HEADER;
                            end
                            acc_next  = '0;
                            hidx_next = '0;
                        end
                    end
                    PH_REP_FIRST:
                    begin
                        held_next  = q_item.data;
                        phase_next = PH_REP_SECOND;
                    end
                    PH_REP_SECOND:
                    begin
                        rep_next   = {q_item.data, held_reg};
                        phase_next = (run_reg != '0) ? PH_EXPAND : PH_HEADER;
                    end
                    PH_LIT_FIRST:
                    begin
                        held_next  = q_item.data;
                        phase_next = PH_LIT_SECOND;
                    end
                    PH_LIT_SECOND:
                    begin
                        res_valid     = 1'b1;
                        word_out      = 1'b1;
                        res.word      = {q_item.data, held_reg};
                        res.chunk_end = chunk_wrap;
                        chunk_next    = chunk_wrap ? '0 : chunk_inc;
                        run_next      = run_dec;
                        phase_next    = (run_dec != '0) ? PH_LIT_FIRST : PH_HEADER;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase

                // Close the stream on its last byte, or defer the close to the last repeat word
                if (q_item.last)
                begin
                    if (phase_next == PH_EXPAND)
                    begin
                        ending_next = 1'b1;
                    end
                    else
                    begin
                        if (word_out)
                        begin
                            res.chunk_end = 1'b1;
                        end
                        phase_next  = PH_HEADER;
                        hidx_next   = '0;
                        acc_next    = '0;
                        run_next    = '0;
                        chunk_next  = '0;
                        ending_next = 1'b0;
                    end
                end
            end
        end
    end

    // Load or drain the output register
    always_comb
    begin
        ovalid_next = ovalid_reg && !out_ready;
        ores_next   = ores_reg;
        if (pop && res_valid)
        begin
            ovalid_next = 1'b1;
            ores_next   = res;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            run_reg    <= '0;
            hidx_reg   <= '0;
            acc_reg    <= '0;
            held_reg   <= '0;
            rep_reg    <= '0;
            chunk_reg  <= '0;
            ending_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            hidx_reg   <= hidx_next;
            acc_reg    <= acc_next;
            held_reg   <= held_next;
            rep_reg    <= rep_next;
            chunk_reg  <= chunk_next;
            ending_reg <= ending_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        ores_reg <= ores_next;
    end

    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;

endmodule

`default_nettype wire

>>> rtl/core/rle16_stopbit_decoder_core.sv
// Run-length decoder for a byte stream of 16-bit words.
// Slave channel: one transaction per byte or tick. s_tuser = 1 asks for one
// repeat word (tick), s_tuser = 0 carries a compressed byte in s_tdata[7:0];
// s_tlast marks the final byte of the compressed stream.
// Master channel: m_tdata[15:0] is the decoded word, m_tlast marks the last
// word of a chunk of CHUNK_WORDS words or of the stream, m_tuser flags a
// protocol error (byte during expansion or overlong header) that carries no
// word. A transaction yields zero or one result.
// Throughput: one slave transaction per cycle, sustained, while m_tready is
// high. The decoder state machine in the back end then retires one queued
// transaction each cycle. A slave transaction passes the input register,
// then a queue entry, then the output register before m_tvalid rises with
// its result.
// When the receiver stalls, the output register holds its result; the queue
// absorbs up to four more transactions plus one in the input register before
// s_tready drops.
// Reset: all control state clears, the decoder waits for a header byte.
`default_nettype none

module rle16_stopbit_decoder_core
#(
    parameter int CHUNK_WORDS      = 512,
    parameter int MAX_HEADER_BYTES = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,    // [7:0] in_byte
    input  wire logic          s_tuser,    // [0] req_type
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,    // [15:0] out_word
    output logic               m_tuser,    // [0] protocol_error
    output logic               m_tlast
);

    logic              fq_valid;
    logic              fq_ready;
    rsd_pkg::item_t    fq_item;
    logic              qb_valid;
    logic              qb_ready;
    rsd_pkg::item_t    qb_item;
    rsd_pkg::result_t  res;

    // Accept and classify
    rsd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    // Decouple front and back
    rsd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Decode and emit
    rsd_back
    #(
        .CHUNK_WORDS      (CHUNK_WORDS),
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = res.word;
    assign m_tlast = res.chunk_end;
    assign m_tuser = res.protocol_error;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

localparam int CHUNK_WORDS      = 512;
localparam int MAX_HEADER_BYTES = 5;

typedef enum int
{
    ST_HEADER,
    ST_REP_LO,
    ST_REP_HI,
    ST_EXPAND,
    ST_LIT_LO,
    ST_LIT_HI
} dec_state_t;

// Predicts decoded words from accepted byte/tick transactions and checks them
class word_checker;
    dec_state_t       state;
    bit [30:0]        run_left;
    int               hdr_idx;
    bit [31:0]        hdr_acc;
    bit [7:0]         first_byte;
    bit [15:0]        rep_word;
    int               chunk_cnt;
    bit               closing;
    rsd_pkg::result_t words_due[$];
    int               mismatches;

    function new();
        end_stream();
        first_byte = '0;
        rep_word   = '0;
        mismatches = 0;
    endfunction

    // Return to the header phase and restart the chunk count
    function void end_stream();
        state     = ST_HEADER;
        hdr_idx   = 0;
        hdr_acc   = '0;
        run_left  = '0;
        chunk_cnt = 0;
        closing   = 1'b0;
    endfunction

    function rsd_pkg::result_t make_word(bit [15:0] w);
        rsd_pkg::result_t r;
        r.word           = w;
        r.chunk_end      = 1'b0;
        r.protocol_error = 1'b0;
        chunk_cnt++;
        if (chunk_cnt >= CHUNK_WORDS)
        begin
            r.chunk_end = 1'b1;
            chunk_cnt   = 0;
        end
        return r;
    endfunction

    function int pending();
        return words_due.size();
    endfunction

    // Advance the decoder by one accepted input transaction
    function void take_item(rsd_pkg::item_kind_t kind, bit [7:0] b, bit last);
        rsd_pkg::result_t r;
        bit               has_result;
        bit               word_out;
        r          = '0;
        has_result = 1'b0;
        word_out   = 1'b0;

        // Ticks only matter while a repeat run is being expanded
        if (kind == rsd_pkg::KIND_TICK)
        begin
            if (state == ST_EXPAND)
            begin
                r        = make_word(rep_word);
                run_left = run_left - 31'd1;
                if (run_left == 0)
                begin
                    state = ST_HEADER;
                    if (closing)
                    begin
                        r.chunk_end = 1'b1;
                        end_stream();
                    end
                end
                words_due.push_back(r);
            end
            return;
        end

        // Drop a data byte during expansion, last flag included
        if (state == ST_EXPAND)
        begin
            r.protocol_error = 1'b1;
            words_due.push_back(r);
            return;
        end

        case (state)
            ST_HEADER:
            begin
                if (hdr_idx < MAX_HEADER_BYTES)
                begin
                    hdr_acc = hdr_acc | (32'(b[6:0]) << (7 * hdr_idx));
                    hdr_idx++;
                end
                else
                begin
                    r.protocol_error = 1'b1;
                    has_result       = 1'b1;
                end
                if (b[7])
                begin
                    run_left = hdr_acc[31:1];
                    if (hdr_acc[0])
                        state = ST_REP_LO;
                    else
                        state = (run_left != 0) ? ST_LIT_LO : ST_HEADER;
                    hdr_acc = '0;
                    hdr_idx = 0;
                end
            end
            ST_REP_LO:
            begin
                first_byte = b;
                state      = ST_REP_HI;
            end
            ST_REP_HI:
            begin
                rep_word = {b, first_byte};
                state    = (run_left != 0) ? ST_EXPAND : ST_HEADER;
            end
            ST_LIT_LO:
            begin
                first_byte = b;
                state      = ST_LIT_HI;
            end
            ST_LIT_HI:
            begin
                r          = make_word({b, first_byte});
                has_result = 1'b1;
                word_out   = 1'b1;
                run_left   = run_left - 31'd1;
                state      = (run_left != 0) ? ST_LIT_LO : ST_HEADER;
            end
            default:
                state = ST_HEADER;
        endcase

        // Stream end: defer to the last tick word if expansion follows
        if (last)
        begin
            if (state == ST_EXPAND)
                closing = 1'b1;
            else
            begin
                if (word_out)
                    r.chunk_end = 1'b1;
                end_stream();
            end
        end
        if (has_result)
            words_due.push_back(r);
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_word(logic [15:0] w, logic ce, logic pe);
        rsd_pkg::result_t want;
        if (words_due.size() == 0)
        begin
            $error("unexpected result: out_word=%h chunk_end=%b protocol_error=%b",
                   w, ce, pe);
            mismatches++;
            return;
        end
        want = words_due.pop_front();
        if (w !== want.word)
        begin
            $error("out_word: expected %h, got %h", want.word, w);
            mismatches++;
        end
        if (ce !== want.chunk_end)
        begin
            $error("chunk_end: expected %b, got %b", want.chunk_end, ce);
            mismatches++;
        end
        if (pe !== want.protocol_error)
        begin
            $error("protocol_error: expected %b, got %b", want.protocol_error, pe);
            mismatches++;
        end
    endfunction
endclass

module tb;
    localparam int RANDOM_ITEMS = 700;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_RUN     = 520;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    word_checker chk;
    bit          idle_on     = 1'b1;
    int          stall_left  = 0;
    int          quiet_cycles = 0;
    int          items_sent  = 0;

    always #2 clk = ~clk;

    rle16_stopbit_decoder_core
    #(
        .CHUNK_WORDS      (CHUNK_WORDS),
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    )
    u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Check accepted results and stall the receiver in random bursts
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            chk.check_word(m_tdata, m_tlast, m_tuser);
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // End the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Present one transaction, hold it until accepted, then update the prediction
    task automatic push_item(rsd_pkg::item_kind_t kind, bit [7:0] b, bit last);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chk.take_item(kind, b, last);
        items_sent++;
    endtask

    function automatic int header_len(bit [31:0] val);
        int n;
        n = 1;
        while (n < 5 && (val >> (7 * n)) != 0)
            n++;
        return n;
    endfunction

    // Send a varint header; pad adds groups (zero up to the fifth byte, random after), past five bytes it overflows
    task automatic send_header(bit [31:0] val, int pad, bit last);
        int       nbytes;
        bit [7:0] b;
        nbytes = header_len(val) + pad;
        for (int i = 0; i < nbytes; i++)
        begin
            if (i < 5)
                b = 8'(val >> (7 * i)) & 8'h7f;
            else
                b = {1'b0, 7'($urandom)};
            // Upper payload bits of the fifth group fall off the 32-bit value
            if (i == 4)
                b[6:4] = 3'($urandom);
            b[7] = (i == nbytes - 1);
            push_item(rsd_pkg::KIND_DATA, b, last && b[7]);
        end
    endtask

    task automatic play_repeat(bit [30:0] count, int pad, bit closes);
        bit [15:0] w;
        w = 16'($urandom);
        send_header({count, 1'b1}, pad, 1'b0);
        push_item(rsd_pkg::KIND_DATA, w[7:0], 1'b0);
        push_item(rsd_pkg::KIND_DATA, w[15:8], closes);
        for (int i = 0; i < int'(count); i++)
        begin
            // Occasionally slip a data byte into the expansion
            if ($urandom_range(0, 15) == 0)
                push_item(rsd_pkg::KIND_DATA, 8'($urandom), 1'($urandom));
            push_item(rsd_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 3) == 0)
            push_item(rsd_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic play_literal(bit [30:0] count, int pad, bit closes);
        send_header({count, 1'b0}, pad, closes && count == 0);
        for (int i = 0; i < int'(count); i++)
        begin
            push_item(rsd_pkg::KIND_DATA, 8'($urandom), 1'b0);
            push_item(rsd_pkg::KIND_DATA, 8'($urandom), closes && i == int'(count) - 1);
        end
    endtask

    // Start a literal run with a huge count and cut it short with a last byte
    task automatic play_cut_literal();
        int npairs;
        send_header({31'($urandom) | 31'd8, 1'b0}, 0, 1'b0);
        npairs = $urandom_range(0, 5);
        repeat (npairs)
        begin
            push_item(rsd_pkg::KIND_DATA, 8'($urandom), 1'b0);
            push_item(rsd_pkg::KIND_DATA, 8'($urandom), 1'b0);
        end
        if ($urandom_range(0, 1) == 1)
            push_item(rsd_pkg::KIND_DATA, 8'($urandom), 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'($urandom), 1'b1);
    endtask

    // Random bytes and ticks; in the header phase a byte always closes the stream
    task automatic play_noise(int n);
        rsd_pkg::item_kind_t kind;
        repeat (n)
        begin
            kind = rsd_pkg::item_kind_t'($urandom_range(0, 1));
            if (chk.state == ST_HEADER && kind == rsd_pkg::KIND_DATA)
                push_item(kind, 8'($urandom), 1'b1);
            else
                push_item(kind, 8'($urandom), 1'($urandom));
        end
    endtask

    // Bring the decoder back to a clean header boundary
    task automatic settle_to_header();
        while (chk.state != ST_HEADER || chk.hdr_idx != 0)
        begin
            if (chk.state == ST_EXPAND)
                push_item(rsd_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
            else
                push_item(rsd_pkg::KIND_DATA, 8'($urandom), 1'b1);
        end
    endtask

    function automatic int pick_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
    endfunction

    initial
    begin
        int  base;
        int  choice;
        bit  long_done;
        chk = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: literal word with extreme bytes
        push_item(rsd_pkg::KIND_DATA, 8'h82, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'hff, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h00, 1'b0);
        // Repeat run whose word bytes close the stream; the tick word ends it
        push_item(rsd_pkg::KIND_DATA, 8'h83, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h34, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h12, 1'b1);
        push_item(rsd_pkg::KIND_TICK, 8'h00, 1'b0);
        // Tick with nothing to expand
        push_item(rsd_pkg::KIND_TICK, 8'hff, 1'b1);
        // Zero-count literal and zero-count repeat
        push_item(rsd_pkg::KIND_DATA, 8'h80, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h81, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'haa, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h55, 1'b0);
        // Overlong header, truncated fifth group, byte during expansion
        push_item(rsd_pkg::KIND_DATA, 8'h03, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h00, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h00, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h00, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h70, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'hff, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h00, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'hff, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'hff, 1'b1);
        push_item(rsd_pkg::KIND_TICK, 8'h00, 1'b0);
        // Maximum literal count, abandoned by the stream end
        send_header(32'hffff_fffe, 0, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h11, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h22, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h33, 1'b0);
        push_item(rsd_pkg::KIND_DATA, 8'h44, 1'b1);
        // Stream end on a header byte
        push_item(rsd_pkg::KIND_DATA, 8'h84, 1'b1);

        // Hold the sender until the pipeline has drained
        s_tvalid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);

        // Random runs, mostly well formed
        base      = items_sent;
        long_done = 1'b0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (items_sent - base > RANDOM_ITEMS - 150)
                idle_on = 1'b0;
            else if ($urandom_range(0, 24) == 0)
                idle_on = !idle_on;

            if (!long_done && items_sent - base > 50)
            begin
                // One run long enough to cross a chunk boundary
                play_repeat(31'(LONG_RUN), 0, 1'b0);
                long_done = 1'b1;
            end
            else
            begin
                choice = $urandom_range(0, 99);
                if (choice < 40)
                    play_repeat(($urandom_range(0, 3) == 0) ? 31'($urandom_range(7, 40))
                                                            : 31'($urandom_range(0, 6)),
                                pick_pad(), $urandom_range(0, 4) == 0);
                else if (choice < 70)
                    play_literal(($urandom_range(0, 3) == 0) ? 31'($urandom_range(7, 20))
                                                             : 31'($urandom_range(0, 6)),
                                 pick_pad(), $urandom_range(0, 4) == 0);
                else if (choice < 78)
                    play_cut_literal();
                else if (choice < 88)
                begin
                    send_header({31'($urandom_range(0, 6)), 1'b1}, pick_pad(), 1'b0);
                    play_noise($urandom_range(1, 4));
                end
                else
                    play_noise($urandom_range(1, 6));
            end
            settle_to_header();
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (chk.mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
